// File: rtl/sqvg_pkg.sv
// package: shared constants, types, sine table and lookup functions for the sprite quad generator
`timescale 1ns / 1ps
`default_nettype none
package sqvg_pkg;

  // quarter-wave sine table size (entries 0..SINE_TABLE_DEPTH)
  localparam int SINE_TABLE_DEPTH = 256;
  localparam int IDX_W            = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int SCALED_W         = 14 + IDX_W;

  // fixed-point constants
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam int              ONE_Q15     = 32768;
  // (0.5 in Q16.16) << 8 plus the half-up rounding bit of the Q.24 offset
  localparam logic signed [40:0] POS_BIAS_Q24 = 41'sd8388736;

  // vertices per sprite
  localparam int VERTS_PER_SPRITE = 6;
  localparam int STEP_W           = 3;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(VERTS_PER_SPRITE - 1);

  typedef enum logic [1:0] {
    CORNER_BL = 2'd0,
    CORNER_BR = 2'd1,
    CORNER_TR = 2'd2,
    CORNER_TL = 2'd3
  } corner_e;

  typedef logic [15:0] sine_tab_t [0:SINE_TABLE_DEPTH];

  // one sprite after the multiply stage, as held in the queue
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [32:0] cos_sx;
    logic signed [32:0] sin_sy;
    logic signed [32:0] sin_sx;
    logic signed [32:0] cos_sy;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
    logic [15:0]        tex_w;
    logic [15:0]        tex_h;
    logic [31:0]        rgba;
  } job_t;

  // quarter sine series in Q30, rounded to Q1.15; evaluated at elaboration only
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t   tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
      x    = (HALF_PI_Q30 * 64'(i)) / 64'(SINE_TABLE_DEPTH);
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int k = 1; k <= 9; k++) begin
        term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
        if ((k & 1) == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      sum = (sum + 64'sd16384) >>> 15;
      if (sum > longint'(ONE_Q15)) begin
        sum = longint'(ONE_Q15);
      end
      tab[i] = 16'(sum);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

  // signed Q1.15 sine of a binary angle, from the quarter-wave table
  function automatic logic signed [16:0] sine_q15(input logic [15:0] angle);
    logic [SCALED_W-1:0] scaled;
    logic [IDX_W-1:0]    idx;
    logic [16:0]         mag;
    scaled = SCALED_W'(angle[13:0]) * SCALED_W'(SINE_TABLE_DEPTH);
    idx    = scaled[SCALED_W-1:14];
    if (angle[14]) begin
      idx = IDX_W'(SINE_TABLE_DEPTH) - idx;
    end
    mag = {1'b0, SINE_TAB[idx]};
    return angle[15] ? -$signed(mag) : $signed(mag);
  endfunction

  // corner emitted at each step of a sprite
  function automatic corner_e corner_of(input logic [STEP_W-1:0] step);
    corner_e c;
    case (step)
      3'd0:    c = CORNER_BL;
      3'd1:    c = CORNER_BR;
      3'd2:    c = CORNER_TR;
      3'd3:    c = CORNER_TR;
      3'd4:    c = CORNER_TL;
      3'd5:    c = CORNER_BL;
      default: c = CORNER_BL;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// File: rtl/sqvg_sprite_if.sv
// interface: sprite input channel with valid/ready handshake
`timescale 1ns / 1ps
`default_nettype none
interface sqvg_sprite_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic [15:0]        angle;
  logic signed [15:0] scale_x;
  logic signed [15:0] scale_y;
  logic [15:0]        tex_u;
  logic [15:0]        tex_v;
  logic [15:0]        tex_w;
  logic [15:0]        tex_h;
  logic [31:0]        rgba;

  modport source (
    output valid, pos_x, pos_y, angle, scale_x, scale_y, tex_u, tex_v, tex_w, tex_h, rgba,
    input  ready
  );
  modport sink (
    input  valid, pos_x, pos_y, angle, scale_x, scale_y, tex_u, tex_v, tex_w, tex_h, rgba,
    output ready
  );
endinterface
`default_nettype wire

// File: rtl/sqvg_vertex_if.sv
// interface: vertex output channel with valid/ready handshake
`timescale 1ns / 1ps
`default_nettype none
interface sqvg_vertex_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] vert_x;
  logic signed [31:0] vert_y;
  logic [16:0]        vert_u;
  logic [16:0]        vert_v;
  logic [31:0]        vert_rgba;
  logic [1:0]         corner;
  logic               last;

  modport source (
    output valid, vert_x, vert_y, vert_u, vert_v, vert_rgba, corner, last,
    input  ready
  );
  modport sink (
    input  valid, vert_x, vert_y, vert_u, vert_v, vert_rgba, corner, last,
    output ready
  );
endinterface
`default_nettype wire

// File: rtl/sqvg_front.sv
// front end: sprite accept, sine/cosine lookup and scale products
`timescale 1ns / 1ps
`default_nettype none
module sqvg_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  sqvg_sprite_if.sink        sprite_i,
  output logic               job_valid_o,
  input  wire logic          job_ready_i,
  output sqvg_pkg::job_t     job_o
);
  import sqvg_pkg::*;

  // lookup stage registers
  logic               v1_q, v1_d;
  logic signed [31:0] pos_x1_q, pos_y1_q;
  logic signed [16:0] sin1_q, cos1_q;
  logic signed [15:0] sx1_q, sy1_q;
  logic [15:0]        tex_u1_q, tex_v1_q, tex_w1_q, tex_h1_q;
  logic [31:0]        rgba1_q;

  // product stage registers
  logic  v2_q, v2_d;
  job_t  job2_q;

  logic adv1, adv2;

  // stall chain back from the queue
  assign adv2           = !v2_q || job_ready_i;
  assign adv1           = !v1_q || adv2;
  assign sprite_i.ready = adv1;

  assign v1_d = adv1 ? sprite_i.valid : v1_q;
  assign v2_d = adv2 ? v1_q : v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
    end
  end

  // angle lookup on transfer
  always_ff @(posedge clk_i) begin
    if (adv1 && sprite_i.valid) begin
      pos_x1_q <= sprite_i.pos_x;
      pos_y1_q <= sprite_i.pos_y;
      sin1_q   <= sine_q15(sprite_i.angle);
      cos1_q   <= sine_q15(sprite_i.angle + 16'h4000);
      sx1_q    <= sprite_i.scale_x;
      sy1_q    <= sprite_i.scale_y;
      tex_u1_q <= sprite_i.tex_u;
      tex_v1_q <= sprite_i.tex_v;
      tex_w1_q <= sprite_i.tex_w;
      tex_h1_q <= sprite_i.tex_h;
      rgba1_q  <= sprite_i.rgba;
    end
  end

  // four scale-by-trig products
  always_ff @(posedge clk_i) begin
    if (adv2 && v1_q) begin
      job2_q.pos_x  <= pos_x1_q;
      job2_q.pos_y  <= pos_y1_q;
      job2_q.cos_sx <= 33'(cos1_q) * 33'(sx1_q);
      job2_q.sin_sy <= 33'(sin1_q) * 33'(sy1_q);
      job2_q.sin_sx <= 33'(sin1_q) * 33'(sx1_q);
      job2_q.cos_sy <= 33'(cos1_q) * 33'(sy1_q);
      job2_q.tex_u  <= tex_u1_q;
      job2_q.tex_v  <= tex_v1_q;
      job2_q.tex_w  <= tex_w1_q;
      job2_q.tex_h  <= tex_h1_q;
      job2_q.rgba   <= rgba1_q;
    end
  end

  assign job_valid_o = v2_q;
  assign job_o       = job2_q;

endmodule
`default_nettype wire

// File: rtl/sqvg_queue.sv
// two-entry queue of prepared sprites between front and back end
`timescale 1ns / 1ps
`default_nettype none
module sqvg_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_valid_i,
  output logic                 push_ready_o,
  input  wire sqvg_pkg::job_t  push_job_i,
  output logic                 pop_valid_o,
  input  wire logic            pop_ready_i,
  output sqvg_pkg::job_t       pop_job_o
);
  import sqvg_pkg::*;

  job_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_job_o    = mem_q[rd_ptr_q];

  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule
`default_nettype wire

// File: rtl/sqvg_back.sv
// back end: corner sequencer, rotated offsets, rounding, saturation and output register
`timescale 1ns / 1ps
`default_nettype none
module sqvg_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            job_valid_i,
  output logic                 job_pop_o,
  input  wire sqvg_pkg::job_t  job_i,
  sqvg_vertex_if.source        vertex_o
);
  import sqvg_pkg::*;

  logic [STEP_W-1:0] step_q, step_d;
  logic              vb_q, vb_d;
  logic              vo_q, vo_d;
  logic              adv_o, adv_b, load;

  // corner stage registers
  logic signed [33:0] rot_x_q, rot_y_q;
  logic signed [31:0] pos_xb_q, pos_yb_q;
  logic [16:0]        u_b_q, v_b_q;
  logic [31:0]        rgba_b_q;
  corner_e            corner_b_q;
  logic               last_b_q;

  // output registers
  logic signed [31:0] vx_q, vy_q;
  logic [16:0]        u_o_q, v_o_q;
  logic [31:0]        rgba_o_q;
  corner_e            corner_o_q;
  logic               last_o_q;

  corner_e            cur_corner;
  logic               right, top;
  logic signed [33:0] term_cx, term_sy, term_sx, term_cy;
  logic signed [40:0] tot_x, tot_y;

  // stall chain back from the vertex channel
  assign adv_o     = !vo_q || vertex_o.ready;
  assign adv_b     = !vb_q || adv_o;
  assign load      = adv_b && job_valid_i;
  assign job_pop_o = load && (step_q == LAST_STEP);

  assign vb_d = adv_b ? job_valid_i : vb_q;
  assign vo_d = adv_o ? vb_q : vo_q;

  always_comb begin
    step_d = step_q;
    if (load) begin
      step_d = (step_q == LAST_STEP) ? '0 : step_q + STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      vb_q   <= 1'b0;
      vo_q   <= 1'b0;
    end else begin
      step_q <= step_d;
      vb_q   <= vb_d;
      vo_q   <= vo_d;
    end
  end

  // signed offset terms for the current corner
  assign cur_corner = corner_of(step_q);
  assign right      = (cur_corner == CORNER_BR) || (cur_corner == CORNER_TR);
  assign top        = (cur_corner == CORNER_TR) || (cur_corner == CORNER_TL);
  assign term_cx    = right ? 34'(job_i.cos_sx) : -34'(job_i.cos_sx);
  assign term_sy    = top   ? 34'(job_i.sin_sy) : -34'(job_i.sin_sy);
  assign term_sx    = right ? 34'(job_i.sin_sx) : -34'(job_i.sin_sx);
  assign term_cy    = top   ? 34'(job_i.cos_sy) : -34'(job_i.cos_sy);

  always_ff @(posedge clk_i) begin
    if (load) begin
      rot_x_q    <= term_cx - term_sy;
      rot_y_q    <= term_sx + term_cy;
      pos_xb_q   <= job_i.pos_x;
      pos_yb_q   <= job_i.pos_y;
      u_b_q      <= 17'(job_i.tex_u) + (right ? 17'(job_i.tex_w) : 17'd0);
      v_b_q      <= 17'(job_i.tex_v) + (top ? 17'(job_i.tex_h) : 17'd0);
      rgba_b_q   <= job_i.rgba;
      corner_b_q <= cur_corner;
      last_b_q   <= (step_q == LAST_STEP);
    end
  end

  // translate in Q.24, round half up to Q16.16
  assign tot_x = (41'(pos_xb_q) <<< 8) + 41'(rot_x_q) + POS_BIAS_Q24;
  assign tot_y = (41'(pos_yb_q) <<< 8) + 41'(rot_y_q) + POS_BIAS_Q24;

  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk_i) begin
    if (adv_o && vb_q) begin
      vx_q       <= sat32(tot_x[40:8]);
      vy_q       <= sat32(tot_y[40:8]);
      u_o_q      <= u_b_q;
      v_o_q      <= v_b_q;
      rgba_o_q   <= rgba_b_q;
      corner_o_q <= corner_b_q;
      last_o_q   <= last_b_q;
    end
  end

  assign vertex_o.valid     = vo_q;
  assign vertex_o.vert_x    = vx_q;
  assign vertex_o.vert_y    = vy_q;
  assign vertex_o.vert_u    = u_o_q;
  assign vertex_o.vert_v    = v_o_q;
  assign vertex_o.vert_rgba = rgba_o_q;
  assign vertex_o.corner    = corner_o_q;
  assign vertex_o.last      = last_o_q;

endmodule
`default_nettype wire

// File: rtl/sprite_quad_vertex_generator.sv
// top level: sprite quad vertex generator, front end, queue and back end
//
//   channel    direction  payload                                         handshake
//   sprite_i   in         pos, angle, scale, texture rectangle, rgba      valid/ready
//   vertex_o   out        vert_x/y, vert_u/v, vert_rgba, corner, last     valid/ready
//
// six vertices per sprite, one per cycle while vertex_o does not stall, set by the
// back-end corner sequencer feeding the single vertex output register.
// a transferred sprite passes the lookup, product, queue, corner and output registers.
// reset clears valid flags, queue pointers, queue fill count and the corner counter only.
// the two-entry queue lets the front end keep taking sprites while vertices stall.
`timescale 1ns / 1ps
`default_nettype none
module sprite_quad_vertex_generator (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  sqvg_sprite_if.sink    sprite_i,
  sqvg_vertex_if.source  vertex_o
);
  import sqvg_pkg::*;

  logic push_valid, push_ready;
  job_t push_job;
  logic pop_valid, pop_ready;
  job_t pop_job;

  // sine/cosine lookup and multiply
  sqvg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sprite_i    (sprite_i),
    .job_valid_o (push_valid),
    .job_ready_i (push_ready),
    .job_o       (push_job)
  );

  // decoupling queue
  sqvg_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_job_o    (pop_job)
  );

  // vertex emission
  sqvg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (pop_valid),
    .job_pop_o   (pop_ready),
    .job_i       (pop_job),
    .vertex_o    (vertex_o)
  );

endmodule
`default_nettype wire

// File: dv/sprite_quad_vertex_generator_tb.sv
// testbench: sprite quad vertex generator, six predicted vertices per sprite checked per transfer
`timescale 1ns / 1ps
module sprite_quad_vertex_generator_tb;
  import sqvg_pkg::*;

  localparam int RANDOM_SPRITES = 142;
  localparam int MAX_GAP        = 13;
  localparam int HOLD_CYCLES    = 400;
  localparam int CHOKE_AT       = 60;
  localparam int CHOKE_SPRITES  = 16;
  localparam int DRAIN_CYCLES   = 12;
  localparam int CYCLE_LIMIT    = 100000;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [15:0]        angle;
    logic signed [15:0] scale_x;
    logic signed [15:0] scale_y;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
    logic [15:0]        tex_w;
    logic [15:0]        tex_h;
    logic [31:0]        rgba;
  } sprite_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic [16:0]        u;
    logic [16:0]        v;
    logic [31:0]        rgba;
    corner_e            corner;
    logic               last;
  } vertex_t;

  // quad predictor and in-order vertex checker
  class quad_scoreboard;
    longint      quarter_wave [0:SINE_TABLE_DEPTH];
    vertex_t     pending_verts [$];
    int unsigned fails;
    int unsigned verts_seen;

    // quarter sine in Q1.15 from a truncated Q30 series
    function new();
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          acc;
      fails      = 0;
      verts_seen = 0;
      for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
        x    = (HALF_PI_Q30 * i) / SINE_TABLE_DEPTH;
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (int k = 1; k <= 9; k++) begin
          term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
          if (k % 2 == 1) begin
            acc = acc - longint'(term);
          end else begin
            acc = acc + longint'(term);
          end
        end
        if (acc < 0) begin
          acc = 0;
        end
        acc = (acc + 16384) >>> 15;
        if (acc > ONE_Q15) begin
          acc = ONE_Q15;
        end
        quarter_wave[i] = acc;
      end
    endfunction

    // signed Q1.15 sine of a binary angle
    function longint sine_of(logic [15:0] ang);
      int idx;
      idx = (int'(ang[13:0]) * SINE_TABLE_DEPTH) >> 14;
      if (ang[14]) begin
        idx = SINE_TABLE_DEPTH - idx;
      end
      return ang[15] ? -quarter_wave[idx] : quarter_wave[idx];
    endfunction

    function logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) begin
        return 32'sh7FFFFFFF;
      end
      if (v < -64'sd2147483648) begin
        return 32'sh80000000;
      end
      return v[31:0];
    endfunction

    // work out the six vertices of an accepted sprite
    function void note_sprite(sprite_t s);
      longint  sn;
      longint  cs;
      longint  dx;
      longint  dy;
      bit      right;
      bit      top;
      vertex_t vtx;
      sn = sine_of(s.angle);
      cs = sine_of(s.angle + 16'd16384);
      for (int k = 0; k < VERTS_PER_SPRITE; k++) begin
        case (k)
          0, 5:    vtx.corner = CORNER_BL;
          1:       vtx.corner = CORNER_BR;
          2, 3:    vtx.corner = CORNER_TR;
          default: vtx.corner = CORNER_TL;
        endcase
        right = (vtx.corner == CORNER_BR) || (vtx.corner == CORNER_TR);
        top   = (vtx.corner == CORNER_TR) || (vtx.corner == CORNER_TL);
        dx    = right ? longint'(s.scale_x) : -longint'(s.scale_x);
        dy    = top ? longint'(s.scale_y) : -longint'(s.scale_y);
        // Q.24 offset rounded half up to Q16.16, then half-unit shift and clamp
        vtx.x    = clamp32(longint'(s.pos_x) + 32768 + ((cs * dx - sn * dy + 128) >>> 8));
        vtx.y    = clamp32(longint'(s.pos_y) + 32768 + ((sn * dx + cs * dy + 128) >>> 8));
        vtx.u    = {1'b0, s.tex_u} + (right ? {1'b0, s.tex_w} : 17'd0);
        vtx.v    = {1'b0, s.tex_v} + (top ? {1'b0, s.tex_h} : 17'd0);
        vtx.rgba = s.rgba;
        vtx.last = (k == VERTS_PER_SPRITE - 1);
        pending_verts.insert(pending_verts.size(), vtx);
      end
    endfunction

    task report(string msg);
      $display("%0t ns mismatch: %s", $time, msg);
      fails++;
    endtask

    task check_vertex(vertex_t got);
      vertex_t exp_v;
      if (pending_verts.size() == 0) begin
        report($sformatf("vertex %0d arrived with no sprite outstanding", verts_seen));
      end else begin
        exp_v = pending_verts.pop_front();
        if (got.x !== exp_v.x)
          report($sformatf("vertex %0d vert_x %h, want %h", verts_seen, got.x, exp_v.x));
        if (got.y !== exp_v.y)
          report($sformatf("vertex %0d vert_y %h, want %h", verts_seen, got.y, exp_v.y));
        if (got.u !== exp_v.u)
          report($sformatf("vertex %0d vert_u %h, want %h", verts_seen, got.u, exp_v.u));
        if (got.v !== exp_v.v)
          report($sformatf("vertex %0d vert_v %h, want %h", verts_seen, got.v, exp_v.v));
        if (got.rgba !== exp_v.rgba)
          report($sformatf("vertex %0d vert_rgba %h, want %h", verts_seen, got.rgba,
                           exp_v.rgba));
        if (got.corner !== exp_v.corner)
          report($sformatf("vertex %0d corner %0d, want %0d", verts_seen, got.corner,
                           exp_v.corner));
        if (got.last !== exp_v.last)
          report($sformatf("vertex %0d last %b, want %b", verts_seen, got.last, exp_v.last));
      end
      verts_seen++;
    endtask
  endclass

  logic           clk_i = 1'b0;
  logic           rst_ni;
  logic           choke_req;
  bit             sender_calm;
  bit             sink_calm;
  quad_scoreboard sb;

  sqvg_sprite_if sprite_bus ();
  sqvg_vertex_if vertex_bus ();

  sprite_quad_vertex_generator i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sprite_i (sprite_bus),
    .vertex_o (vertex_bus)
  );

  // clock
  always #1 clk_i = ~clk_i;

  // cycle limit
  initial begin
    int cycles;
    for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) begin
      @(posedge clk_i);
    end
    $display("*** FAILED ***");
    $finish;
  end

  task automatic drive_payload(input sprite_t s);
    sprite_bus.pos_x   <= s.pos_x;
    sprite_bus.pos_y   <= s.pos_y;
    sprite_bus.angle   <= s.angle;
    sprite_bus.scale_x <= s.scale_x;
    sprite_bus.scale_y <= s.scale_y;
    sprite_bus.tex_u   <= s.tex_u;
    sprite_bus.tex_v   <= s.tex_v;
    sprite_bus.tex_w   <= s.tex_w;
    sprite_bus.tex_h   <= s.tex_h;
    sprite_bus.rgba    <= s.rgba;
  endtask

  // offer one sprite after a random gap, or at once when eager, and wait for its transfer
  task automatic send_sprite(input sprite_t s, input bit eager);
    int gap;
    gap = eager ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      sprite_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    drive_payload(s);
    sprite_bus.valid <= 1'b1;
    do @(posedge clk_i); while (sprite_bus.ready !== 1'b1);
    sb.note_sprite(s);
  endtask

  function automatic sprite_t mk_sprite(input logic [31:0] px, input logic [31:0] py,
                                        input logic [15:0] ang, input logic [15:0] sx,
                                        input logic [15:0] sy, input logic [15:0] tu,
                                        input logic [15:0] tv, input logic [15:0] tw,
                                        input logic [15:0] th, input logic [31:0] col);
    sprite_t s;
    s = '{px, py, ang, sx, sy, tu, tv, tw, th, col};
    return s;
  endfunction

  // random sprite, some steered to clamping, small scales, quadrant edges and texture overflow
  function automatic sprite_t rand_sprite();
    sprite_t s;
    int      mode;
    s.pos_x   = $urandom;
    s.pos_y   = $urandom;
    s.angle   = 16'($urandom);
    s.scale_x = 16'($urandom);
    s.scale_y = 16'($urandom);
    s.tex_u   = 16'($urandom);
    s.tex_v   = 16'($urandom);
    s.tex_w   = 16'($urandom);
    s.tex_h   = 16'($urandom);
    s.rgba    = $urandom;
    mode      = $urandom_range(0, 9);
    case (mode)
      0: begin
        s.pos_x = 32'h7FFFFFFF - $urandom_range(0, 1 << 24);
        s.pos_y = 32'h7FFFFFFF - $urandom_range(0, 1 << 24);
      end
      1: begin
        s.pos_x = 32'h80000000 + $urandom_range(0, 1 << 24);
        s.pos_y = 32'h80000000 + $urandom_range(0, 1 << 24);
      end
      2: begin
        s.scale_x = 16'($urandom_range(0, 2047) - 1024);
        s.scale_y = 16'($urandom_range(0, 2047) - 1024);
      end
      3: s.angle = 16'(($urandom_range(0, 3) << 14) + $urandom_range(0, 4) - 2);
      4: begin
        s.tex_u = 16'hFFFF - 16'($urandom_range(0, 255));
        s.tex_w = 16'hFFFF - 16'($urandom_range(0, 255));
      end
      default: ;
    endcase
    return s;
  endfunction

  // vertex sink with random stalls and one long hold-off
  initial begin
    int      gap;
    int      hold;
    int      taken;
    vertex_t got;
    taken = 0;
    sink_calm = 1'b0;
    vertex_bus.ready <= 1'b0;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      if (choke_req) begin
        vertex_bus.ready <= 1'b0;
        for (hold = 0; hold < HOLD_CYCLES; hold++) begin
          @(posedge clk_i);
        end
        choke_req <= 1'b0;
      end
      gap = sink_calm ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
        vertex_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      vertex_bus.ready <= 1'b1;
      do @(posedge clk_i); while (vertex_bus.valid !== 1'b1);
      got.x      = vertex_bus.vert_x;
      got.y      = vertex_bus.vert_y;
      got.u      = vertex_bus.vert_u;
      got.v      = vertex_bus.vert_v;
      got.rgba   = vertex_bus.vert_rgba;
      got.corner = corner_e'(vertex_bus.corner);
      got.last   = vertex_bus.last;
      sb.check_vertex(got);
      taken++;
      if (taken % 48 == 0) begin
        sink_calm = ($urandom_range(0, 3) == 0);
      end
    end
  end

  // reset, directed sprites, random sprites, drain
  initial begin
    sb          = new();
    sender_calm = 1'b0;
    rst_ni     <= 1'b0;
    choke_req  <= 1'b0;
    sprite_bus.valid <= 1'b0;
    drive_payload('0);
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // identity, quadrant boundaries, near-boundary angles
    send_sprite(mk_sprite(0, 0, 16'd0, 16'd256, 16'd256, 0, 0, 0, 0, 0), 1'b0);
    send_sprite(mk_sprite(32'h00010000, 32'h00020000, 16'd16384, 16'd256, 16'd256,
                          16'h1000, 16'h2000, 16'h4000, 16'h4000, 32'h11223344), 1'b0);
    send_sprite(mk_sprite(32'h00050000, 32'hFFFB0000, 16'd32768, 16'd512, 16'd128,
                          16'h0100, 16'h0200, 16'h0300, 16'h0400, 32'hA5A5A5A5), 1'b0);
    send_sprite(mk_sprite(32'hFFFF8000, 32'h00008000, 16'd49152, 16'd384, 16'd640,
                          16'h8000, 16'h8000, 16'h8000, 16'h8000, 32'h5A5A5A5A), 1'b0);
    send_sprite(mk_sprite(0, 0, 16'd16383, 16'd256, 16'd256, 0, 0, 0, 0, 0), 1'b0);
    send_sprite(mk_sprite(0, 0, 16'd16385, 16'd256, 16'd256, 0, 0, 0, 0, 0), 1'b0);
    // scale extremes, full texture rectangle, all-ones colour
    send_sprite(mk_sprite(0, 0, 16'd65535, 16'h8000, 16'h8000, 0, 0, 0, 0, 32'h0), 1'b0);
    send_sprite(mk_sprite(0, 0, 16'd8192, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF,
                          16'hFFFF, 16'hFFFF, 32'hFFFFFFFF), 1'b0);
    send_sprite(mk_sprite(0, 0, 16'd24576, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF,
                          16'hFFFF, 16'h0000, 32'h01020304), 1'b0);
    // position clamping at both ends
    send_sprite(mk_sprite(32'h7FFFFFFF, 32'h7FFFFFFF, 16'd0, 16'h7FFF, 16'h7FFF,
                          0, 0, 0, 0, 0), 1'b0);
    send_sprite(mk_sprite(32'h80000000, 32'h80000000, 16'd0, 16'h7FFF, 16'h7FFF,
                          0, 0, 0, 0, 0), 1'b0);
    send_sprite(mk_sprite(32'h7FFFFFFF, 32'h80000000, 16'd8192, 16'h8000, 16'h8000,
                          0, 0, 0, 0, 0), 1'b0);
    // zero scale: exactly at and one past the clamp edge
    send_sprite(mk_sprite(32'h7FFF7FFF, 32'h7FFF8000, 16'd0, 16'd0, 16'd0,
                          0, 0, 0, 0, 0), 1'b0);
    send_sprite(mk_sprite(32'h80000000, 32'h80000000, 16'd12345, 16'd0, 16'd0,
                          0, 0, 0, 0, 0), 1'b0);
    // mirrored quad and tiny scales that hit the rounding step
    send_sprite(mk_sprite(0, 0, 16'd1, 16'hFF00, 16'd512, 16'h1234, 16'h5678,
                          16'h1111, 16'h2222, 32'hDEADBEEF), 1'b0);
    send_sprite(mk_sprite(0, 0, 16'd4096, 16'd1, 16'd1, 0, 0, 0, 0, 0), 1'b0);
    send_sprite(mk_sprite(0, 0, 16'd40000, 16'hFFFF, 16'd3, 0, 0, 0, 0, 0), 1'b0);
    send_sprite(mk_sprite(32'h12345678, 32'h9ABCDEF0, 16'd57344, 16'd300, 16'hFED4,
                          16'h0001, 16'h0001, 16'hFFFF, 16'hFFFF, 32'h80000001), 1'b1);

    // random sprites, with a long sink hold-off while sprites keep coming
    for (int i = 0; i < RANDOM_SPRITES; i++) begin
      if (i == CHOKE_AT) begin
        choke_req <= 1'b1;
      end
      send_sprite(rand_sprite(),
                  sender_calm || (i >= CHOKE_AT && i < CHOKE_AT + CHOKE_SPRITES));
      if (i % 40 == 39) begin
        sender_calm = ($urandom_range(0, 2) == 0);
      end
    end
    sprite_bus.valid <= 1'b0;

    while (sb.pending_verts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/sqvg_pkg.sv
rtl/sqvg_sprite_if.sv
rtl/sqvg_vertex_if.sv
rtl/sqvg_front.sv
rtl/sqvg_queue.sv
rtl/sqvg_back.sv
rtl/sprite_quad_vertex_generator.sv
dv/sprite_quad_vertex_generator_tb.sv
